// File: hw/rtl/fopa_pkg.sv
package fopa_pkg;

    // Pool geometry. The handle ports are four bits wide, so the pool size is fixed with them.
    localparam int POOL_SIZE = 16;
    localparam int HANDLE_W  = 4;
    localparam int PTR_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    // Request kinds.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TRY   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

    typedef logic [HANDLE_W-1:0] t_handle;

    // Commands from the pool control to the free-handle queue.
    typedef struct packed {
        logic    push;
        logic    pop;
        t_handle push_data;
    } t_fifo_cmd;

    // Queue status seen by the pool control.
    typedef struct packed {
        logic    empty;
        logic    full;
        t_handle head_data;
    } t_fifo_stat;

    // One result word.
    typedef struct packed {
        t_handle             handle;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// File: hw/rtl/fopa_free_fifo.sv
module fopa_free_fifo
    import fopa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fifo_cmd  i_cmd,
    output t_fifo_stat o_stat
);

    t_handle              r_mem [POOL_SIZE];
    t_handle              r_head_data;
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;
    logic [PTR_W-1:0]     n_head;
    logic [PTR_W-1:0]     n_tail;
    logic [CNT_W-1:0]     n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.pop) begin
            n_head  = (r_head == PTR_W'(POOL_SIZE - 1)) ? '0 : r_head + 1'b1;
            n_count = n_count - 1'b1;
        end
        if (i_cmd.push) begin
            n_tail  = (r_tail == PTR_W'(POOL_SIZE - 1)) ? '0 : r_tail + 1'b1;
            n_count = n_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entries carry no reset: one is only read after it has been written.
    // The word at the next head position is fetched ahead, and a word pushed
    // into that position is passed straight through.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_cmd.push_data;
        end
        if (i_cmd.push && (r_tail == n_head)) begin
            r_head_data <= i_cmd.push_data;
        end else begin
            r_head_data <= r_mem[n_head];
        end
    end

    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(POOL_SIZE));
    assign o_stat.head_data = r_head_data;

endmodule

// File: hw/rtl/fopa_pool_core.sv
module fopa_pool_core
    import fopa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [FUNC_W-1:0] i_func,
    input  t_handle           i_handle,
    output t_result           o_result
);

    logic [POOL_SIZE-1:0] r_held;
    logic [POOL_SIZE-1:0] n_held;
    logic [CNT_W-1:0]     r_created;
    logic [CNT_W-1:0]     n_created;
    t_fifo_cmd            w_cmd;
    t_fifo_stat           w_stat;
    logic                 w_hin_ok;

    fopa_free_fifo u_free_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

    assign w_hin_ok = (CNT_W'(i_handle) < CNT_W'(POOL_SIZE)) &&
                      r_held[i_handle[PTR_W-1:0]];

    always_comb begin
        n_held          = r_held;
        n_created       = r_created;
        w_cmd.push      = 1'b0;
        w_cmd.pop       = 1'b0;
        w_cmd.push_data = i_handle;
        o_result.handle = '0;
        o_result.status = ST_OK;
        unique case (i_func)
            FUNC_ALLOC, FUNC_TRY: begin
                priority if (!w_stat.empty) begin
                    w_cmd.pop       = i_fire;
                    o_result.handle = w_stat.head_data;
                    n_held[w_stat.head_data[PTR_W-1:0]] = 1'b1;
                end else if (i_func == FUNC_TRY) begin
                    o_result.status = ST_EMPTY;
                end else if (r_created == CNT_W'(POOL_SIZE)) begin
                    o_result.status = ST_EXHAUSTED;
                end else begin
                    o_result.handle = HANDLE_W'(r_created);
                    n_created       = r_created + 1'b1;
                    n_held[r_created[PTR_W-1:0]] = 1'b1;
                end
            end
            FUNC_FREE: begin
                // A full queue cannot coexist with a held handle, but it is rejected all the same.
                if (!w_hin_ok || w_stat.full) begin
                    o_result.status = ST_INVALID;
                end else begin
                    w_cmd.push = i_fire;
                    n_held[i_handle[PTR_W-1:0]] = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_created <= '0;
        end else if (i_fire) begin
            r_held    <= n_held;
            r_created <= n_created;
        end
    end

endmodule

// File: hw/rtl/fifo_object_pool_allocator_unit.sv
// Channel  Direction  Ports            Contents
// s_axis   in         tdata, tuser     tdata: handle_in[3:0]; tuser: func[1:0]
// m_axis   out        tdata, tuser     tdata: handle_out[3:0]; tuser: status[1:0]
//
// One request is taken every cycle while m_axis does not stall; its result word is valid once
// it has passed from the input register into the output register.
// The request is held in an input register, served against the queue and held bitmap,
// and the answer is stored in an output register. A stall on m_axis holds both stages,
// and s_axis keeps taking words while the input register is free to move on.
// Reset (synchronous, active low) empties the queue and clears the bitmap and counter.
module fifo_object_pool_allocator_unit
    import fopa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [3:0] handle_in, [7:4] zero
    input  logic [1:0] s_axis_tuser,   // [1:0] func
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [3:0] handle_out, [7:4] zero
    output logic [1:0] m_axis_tuser    // [1:0] status
);

    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    t_handle           r_handle;
    logic              r_out_valid;
    t_result           r_out;
    t_result           w_result;
    logic              w_move;

    assign w_move        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;

    fopa_pool_core u_pool_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_move),
        .i_func   (r_func),
        .i_handle (r_handle),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func   <= s_axis_tuser;
            r_handle <= s_axis_tdata[HANDLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - HANDLE_W){1'b0}}, r_out.handle};
    assign m_axis_tuser  = r_out.status;

endmodule

// File: tb/tb_fifo_object_pool_allocator_unit.sv
module tb_fifo_object_pool_allocator_unit;
    import fopa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth request code is reserved; the block answers it with a plain OK word.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;    // [3:0] handle_in, [7:4] zero
    logic [1:0] s_axis_tuser = '0;    // [1:0] func
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [3:0] handle_out, [7:4] zero
    logic [1:0] m_axis_tuser;         // [1:0] status

    fifo_object_pool_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow of the pool: released handles in order, held bits and creation count.
    t_handle                 released_handles[$];
    logic [POOL_SIZE-1:0]    held_bits = '0;
    int                      created_num = 0;

    t_result pending_results[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      cycle_count = 0;
    int      error_count = 0;
    int      words_checked = 0;
    int      n_requests = 0;
    int      n_grants = 0;
    int      n_releases = 0;
    int      n_invalid = 0;
    int      n_empty = 0;
    int      n_exhausted = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_fifo_object_pool_allocator_unit NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: handle_out %0d status %0d",
                       m_axis_tdata[3:0], m_axis_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (m_axis_tdata[3:0] !== want.handle) begin
                    $error("handle_out: expected %0d, got %0d", want.handle, m_axis_tdata[3:0]);
                    error_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    function automatic t_result predict_pool_answer(input logic [FUNC_W-1:0] func,
                                                    input t_handle handle_in);
        t_result r;
        r.handle = '0;
        r.status = ST_OK;
        case (func)
            FUNC_ALLOC, FUNC_TRY: begin
                if (released_handles.size() != 0) begin
                    r.handle = released_handles.pop_front();
                    held_bits[r.handle] = 1'b1;
                    n_grants++;
                end else if (func == FUNC_TRY) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else if (created_num >= POOL_SIZE) begin
                    r.status = ST_EXHAUSTED;
                    n_exhausted++;
                end else begin
                    r.handle = t_handle'(created_num);
                    created_num++;
                    held_bits[r.handle] = 1'b1;
                    n_grants++;
                end
            end
            FUNC_FREE: begin
                if (!held_bits[handle_in]) begin
                    r.status = ST_INVALID;
                    n_invalid++;
                end else begin
                    held_bits[handle_in] = 1'b0;
                    released_handles.push_back(handle_in);
                    n_releases++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_request(input logic [FUNC_W-1:0] func, input t_handle handle_in);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, handle_in};
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_pool_answer(func, handle_in));
        n_requests++;
    endtask

    task automatic wait_for_all_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic t_handle pick_held_handle();
        t_handle held_list[$];
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (held_bits[i]) held_list.push_back(t_handle'(i));
        end
        if (held_list.size() == 0) return t_handle'($urandom_range(POOL_SIZE - 1));
        return held_list[$urandom_range(held_list.size() - 1)];
    endfunction

    // Mostly legal alloc/free traffic, swinging between alloc-heavy and free-heavy
    // stretches so the pool both runs dry and refills; the rest is stray releases and reserved request codes.
    task automatic run_mixed_traffic(input int n_items);
        int roll;
        int alloc_weight;
        for (int k = 0; k < n_items; k++) begin
            alloc_weight = ((k / 32) % 2 == 0) ? 60 : 30;
            roll = $urandom_range(99);
            if (roll < alloc_weight)
                send_request(FUNC_ALLOC, t_handle'($urandom_range(15)));
            else if (roll < alloc_weight + 12)
                send_request(FUNC_TRY, t_handle'($urandom_range(15)));
            else if (roll < 93)
                send_request(FUNC_FREE, pick_held_handle());
            else if (roll < 98)
                send_request(FUNC_FREE, t_handle'($urandom_range(15)));
            else
                send_request(FUNC_UNUSED, t_handle'($urandom_range(15)));
        end
    endtask

    task automatic test_reset_and_exhaustion();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_request(FUNC_TRY, 4'd0);
        send_request(FUNC_FREE, 4'd3);
        for (int i = 0; i < POOL_SIZE; i++) send_request(FUNC_ALLOC, 4'd0);
        send_request(FUNC_ALLOC, 4'd0);
        send_request(FUNC_TRY, 4'd15);
    endtask

    task automatic test_release_order_and_rejects();
        send_request(FUNC_FREE, 4'd15);
        send_request(FUNC_FREE, 4'd0);
        send_request(FUNC_FREE, 4'd5);
        send_request(FUNC_FREE, 4'd5);
        send_request(FUNC_UNUSED, 4'd10);
        send_request(FUNC_TRY, 4'd0);
        send_request(FUNC_ALLOC, 4'd0);
        send_request(FUNC_ALLOC, 4'd0);
        send_request(FUNC_ALLOC, 4'd0);
        wait_for_all_results();
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_mixed_traffic(225);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct = 71;
        recv_stall_pct = 0;
        run_mixed_traffic(110);
        wait_for_all_results();
        run_mixed_traffic(115);
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 71;
        run_mixed_traffic(225);
    endtask

    task automatic test_both_sides_idle();
        send_idle_pct = 26;
        recv_stall_pct = 26;
        run_mixed_traffic(225);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_and_exhaustion();
        test_release_order_and_rejects();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_backpressure();
        test_both_sides_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        recv_stall_pct = 0;
        $display("%0d requests sent, %0d result words checked, under four idling regimes.",
                 n_requests, words_checked);
        $display("Grants %0d, releases %0d, invalid releases %0d, empty tries %0d, exhausted %0d.",
                 n_grants, n_releases, n_invalid, n_empty, n_exhausted);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_fifo_object_pool_allocator_unit OK");
        end else begin
            $display("tb_fifo_object_pool_allocator_unit NOT OK");
        end
        $finish;
    end

endmodule

// File: fifo_object_pool_allocator_unit.f
hw/rtl/fopa_pkg.sv
hw/rtl/fopa_free_fifo.sv
hw/rtl/fopa_pool_core.sv
hw/rtl/fifo_object_pool_allocator_unit.sv
tb/tb_fifo_object_pool_allocator_unit.sv
